// ===== rtl/tess_pkg.sv =====
// ----------------------------------------------------------------------------
// tess_pkg
// Shared types and constants for the timed event slot scheduler.
// ----------------------------------------------------------------------------
package tess_pkg;

    localparam int SLOTS_DEF  = 16;
    localparam int MAX_FIRED  = 16;
    localparam int NF_W       = $clog2(MAX_FIRED + 1);
    localparam int TIME_W     = 32;
    localparam int TAG_W      = 16;
    localparam int GEN_W      = 16;
    localparam int HIDX_W     = 16;
    localparam int SLOT_IDX_W = 6;
    localparam int REQ_W      = 2;

    localparam logic [REQ_W-1:0] REQ_SCHED  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CANCEL = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SUM
    } state_t;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic chk_en;
        logic sum_en;
    } dp_cmd_t;

endpackage

// ===== rtl/tess_ctrl.sv =====
// ----------------------------------------------------------------------------
// tess_ctrl
// Request sequencer: accepts a request, steps the slot scan one slot per
// cycle and triggers the summary.
// ----------------------------------------------------------------------------
module tess_ctrl #(
    parameter int SLOTS = tess_pkg::SLOTS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    output tess_pkg::dp_cmd_t                      cmd,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_idx,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] chk_idx
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    tess_pkg::state_t   state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               chk_en_reg, chk_en_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic               rd_valid;

    assign rd_idx   = cnt_reg[IDX_W-1:0];
    assign rd_valid = (cnt_reg < CNT_W'(SLOTS));
    assign chk_idx  = chk_idx_reg;
    assign busy     = (state_reg != tess_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tess_pkg::ST_IDLE;
            cnt_reg    <= '0;
            chk_en_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            chk_en_reg <= chk_en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= chk_idx_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        chk_en_next  = 1'b0;
        chk_idx_next = rd_idx;
        cmd          = '0;
        cmd.chk_en   = chk_en_reg;
        case (state_reg)
            tess_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = tess_pkg::ST_SCAN;
                end
            end
            tess_pkg::ST_SCAN:
            begin
                if (rd_valid)
                begin
                    cmd.rd_en   = 1'b1;
                    chk_en_next = 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = tess_pkg::ST_SUM;
                end
            end
            tess_pkg::ST_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = tess_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tess_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/tess_dpath.sv =====
// ----------------------------------------------------------------------------
// tess_dpath
// Slot table and scan datapath: allocation, cancel, firing and
// next-deadline selection, one slot per cycle; result registers.
// ----------------------------------------------------------------------------
module tess_dpath #(
    parameter int SLOTS = tess_pkg::SLOTS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  tess_pkg::dp_cmd_t                      cmd,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_idx,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] chk_idx,
    input  logic [tess_pkg::REQ_W-1:0]             req_type,
    input  logic [tess_pkg::TIME_W-1:0]            current_time,
    input  logic [tess_pkg::TIME_W-1:0]            deadline,
    input  logic [tess_pkg::TAG_W-1:0]             event_tag,
    input  logic [tess_pkg::HIDX_W-1:0]            handle_index,
    input  logic [tess_pkg::GEN_W-1:0]             handle_generation,
    output logic                                   result_valid,
    output logic                                   result_kind,
    output logic                                   status,
    output logic [tess_pkg::SLOT_IDX_W-1:0]        slot_index,
    output logic [tess_pkg::GEN_W-1:0]             slot_generation,
    output logic [tess_pkg::TAG_W-1:0]             fired_tag,
    output logic [tess_pkg::TIME_W-1:0]            next_deadline,
    output logic                                   next_valid,
    output logic                                   fire_now,
    output logic                                   last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // request registers
    logic [tess_pkg::REQ_W-1:0]   req_reg;
    logic [tess_pkg::TIME_W-1:0]  now_reg;
    logic [tess_pkg::TIME_W-1:0]  dl_reg;
    logic [tess_pkg::TAG_W-1:0]   tag_reg;
    logic [tess_pkg::HIDX_W-1:0]  hidx_reg;
    logic [tess_pkg::GEN_W-1:0]   hgen_reg;

    // slot table
    logic [SLOTS-1:0]             pending_reg, pending_next;
    logic [SLOTS-1:0]             gen_ok_reg, gen_ok_next;
    logic [tess_pkg::TIME_W-1:0]  dl_mem  [SLOTS];
    logic [tess_pkg::TAG_W-1:0]   tag_mem [SLOTS];
    logic [tess_pkg::GEN_W-1:0]   gen_mem [SLOTS];
    logic [tess_pkg::TIME_W-1:0]  dl_q;
    logic [tess_pkg::TAG_W-1:0]   tag_q;
    logic [tess_pkg::GEN_W-1:0]   gen_q;

    // scan state
    logic [tess_pkg::NF_W-1:0]    nfired_reg, nfired_next;
    logic                         alloc_done_reg, alloc_done_next;
    logic                         status_reg, status_next;
    logic [IDX_W-1:0]             s_idx_reg, s_idx_next;
    logic [tess_pkg::GEN_W-1:0]   s_gen_reg, s_gen_next;
    logic                         found_reg, found_next;
    logic                         lock_reg, lock_next;
    logic [tess_pkg::TIME_W-1:0]  best_dt_reg, best_dt_next;
    logic [tess_pkg::TIME_W-1:0]  ts_reg, ts_next;

    // check stage
    logic                         pend;
    logic [tess_pkg::GEN_W-1:0]   gen_cur;
    logic [tess_pkg::GEN_W-1:0]   gen_inc;
    logic [tess_pkg::GEN_W-1:0]   gen_new;
    logic                         alloc;
    logic                         fire;
    logic                         pend_eff;
    logic [tess_pkg::TIME_W-1:0]  dl_eff;
    logic [tess_pkg::TIME_W-1:0]  due_diff;
    logic [tess_pkg::TIME_W-1:0]  dt;
    logic [tess_pkg::TIME_W-1:0]  sum_diff;

    // result registers
    logic                         out_valid_reg, out_valid_next;
    logic                         kind_reg, kind_next;
    logic                         ostat_reg, ostat_next;
    logic [tess_pkg::SLOT_IDX_W-1:0] oidx_reg, oidx_next;
    logic [tess_pkg::GEN_W-1:0]   ogen_reg, ogen_next;
    logic [tess_pkg::TAG_W-1:0]   otag_reg, otag_next;
    logic [tess_pkg::TIME_W-1:0]  ond_reg, ond_next;
    logic                         onv_reg, onv_next;
    logic                         ofn_reg, ofn_next;
    logic                         olast_reg, olast_next;

    assign result_valid    = out_valid_reg;
    assign result_kind     = kind_reg;
    assign status          = ostat_reg;
    assign slot_index      = oidx_reg;
    assign slot_generation = ogen_reg;
    assign fired_tag       = otag_reg;
    assign next_deadline   = ond_reg;
    assign next_valid      = onv_reg;
    assign fire_now        = ofn_reg;
    assign last            = olast_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= req_type;
            now_reg  <= current_time;
            dl_reg   <= deadline;
            tag_reg  <= event_tag;
            hidx_reg <= handle_index;
            hgen_reg <= handle_generation;
        end
    end

    // slot memories: one write at the check slot, one read at the next slot
    always_ff @(posedge clk)
    begin
        if (alloc)
        begin
            dl_mem[chk_idx]  <= dl_reg;
            tag_mem[chk_idx] <= tag_reg;
            gen_mem[chk_idx] <= gen_new;
        end
        if (cmd.rd_en)
        begin
            dl_q  <= dl_mem[rd_idx];
            tag_q <= tag_mem[rd_idx];
            gen_q <= gen_mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= '0;
            gen_ok_reg     <= '0;
            nfired_reg     <= '0;
            alloc_done_reg <= 1'b0;
            status_reg     <= 1'b0;
            found_reg      <= 1'b0;
            lock_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pending_reg    <= pending_next;
            gen_ok_reg     <= gen_ok_next;
            nfired_reg     <= nfired_next;
            alloc_done_reg <= alloc_done_next;
            status_reg     <= status_next;
            found_reg      <= found_next;
            lock_reg       <= lock_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_idx_reg   <= s_idx_next;
        s_gen_reg   <= s_gen_next;
        best_dt_reg <= best_dt_next;
        ts_reg      <= ts_next;
        kind_reg    <= kind_next;
        ostat_reg   <= ostat_next;
        oidx_reg    <= oidx_next;
        ogen_reg    <= ogen_next;
        otag_reg    <= otag_next;
        ond_reg     <= ond_next;
        onv_reg     <= onv_next;
        ofn_reg     <= ofn_next;
        olast_reg   <= olast_next;
    end

    assign pend     = pending_reg[chk_idx];
    assign gen_cur  = gen_ok_reg[chk_idx] ? gen_q : '0;
    assign gen_inc  = gen_cur + 1'b1;
    assign gen_new  = (gen_inc == '0) ? tess_pkg::GEN_W'(1) : gen_inc;
    assign due_diff = now_reg - dl_q;
    assign dt       = dl_eff - now_reg;
    assign sum_diff = now_reg - ts_reg;

    always_comb
    begin
        pending_next    = pending_reg;
        gen_ok_next     = gen_ok_reg;
        nfired_next     = nfired_reg;
        alloc_done_next = alloc_done_reg;
        status_next     = status_reg;
        s_idx_next      = s_idx_reg;
        s_gen_next      = s_gen_reg;
        found_next      = found_reg;
        lock_next       = lock_reg;
        best_dt_next    = best_dt_reg;
        ts_next         = ts_reg;
        alloc           = 1'b0;
        fire            = 1'b0;
        pend_eff        = pend;
        dl_eff          = dl_q;

        if (cmd.load)
        begin
            status_next     = (req_type != tess_pkg::REQ_TICK);
            s_idx_next      = '0;
            s_gen_next      = '0;
            nfired_next     = '0;
            alloc_done_next = 1'b0;
            found_next      = 1'b0;
            lock_next       = 1'b0;
            best_dt_next    = '0;
            ts_next         = '0;
        end
        else if (cmd.chk_en)
        begin
            case (req_reg)
                tess_pkg::REQ_SCHED:
                begin
                    if (!alloc_done_reg && !pend)
                    begin
                        alloc                 = 1'b1;
                        alloc_done_next       = 1'b1;
                        pending_next[chk_idx] = 1'b1;
                        gen_ok_next[chk_idx]  = 1'b1;
                        status_next           = 1'b0;
                        s_idx_next            = chk_idx;
                        s_gen_next            = gen_new;
                        pend_eff              = 1'b1;
                        dl_eff                = dl_reg;
                    end
                end
                tess_pkg::REQ_CANCEL:
                begin
                    if (pend && (hgen_reg != '0) && (gen_cur == hgen_reg) &&
                        (hidx_reg == tess_pkg::HIDX_W'(chk_idx)))
                    begin
                        pending_next[chk_idx] = 1'b0;
                        status_next           = 1'b0;
                        pend_eff              = 1'b0;
                    end
                end
                tess_pkg::REQ_TICK:
                begin
                    if (pend && !due_diff[tess_pkg::TIME_W-1] &&
                        (nfired_reg < tess_pkg::NF_W'(tess_pkg::MAX_FIRED)))
                    begin
                        fire                  = 1'b1;
                        pending_next[chk_idx] = 1'b0;
                        nfired_next           = nfired_reg + 1'b1;
                        pend_eff              = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase

            // first overdue slot wins outright, else nearest future one
            if (pend_eff && !lock_reg)
            begin
                if (dt[tess_pkg::TIME_W-1])
                begin
                    ts_next    = dl_eff;
                    found_next = 1'b1;
                    lock_next  = 1'b1;
                end
                else if (!found_reg || (dt < best_dt_reg))
                begin
                    best_dt_next = dt;
                    ts_next      = dl_eff;
                    found_next   = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = fire | cmd.sum_en;
        kind_next      = 1'b0;
        ostat_next     = 1'b0;
        oidx_next      = '0;
        ogen_next      = '0;
        otag_next      = '0;
        ond_next       = '0;
        onv_next       = 1'b0;
        ofn_next       = 1'b0;
        olast_next     = 1'b0;
        if (fire)
        begin
            kind_next = 1'b1;
            oidx_next = tess_pkg::SLOT_IDX_W'(chk_idx);
            otag_next = tag_q;
        end
        else if (cmd.sum_en)
        begin
            ostat_next = status_reg;
            oidx_next  = tess_pkg::SLOT_IDX_W'(s_idx_reg);
            ogen_next  = s_gen_reg;
            ond_next   = found_reg ? ts_reg : '0;
            onv_next   = found_reg;
            ofn_next   = found_reg && !sum_diff[tess_pkg::TIME_W-1];
            olast_next = 1'b1;
        end
    end

    a_fire_limit: assert property (@(posedge clk) disable iff (!rst_n)
        nfired_reg <= tess_pkg::NF_W'(tess_pkg::MAX_FIRED))
        else $error("fire count beyond limit");

    a_sum_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sum_en |=> (result_valid && last && !result_kind))
        else $error("summary not delivered as final result");

    a_fire_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_kind) |-> (req_reg == tess_pkg::REQ_TICK && !last))
        else $error("fired event outside a tick");

    a_lock_found: assert property (@(posedge clk) disable iff (!rst_n)
        lock_reg |-> found_reg)
        else $error("overdue lock without a chosen slot");

    a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
        alloc |-> (req_reg == tess_pkg::REQ_SCHED && !pend && !alloc_done_reg))
        else $error("allocation of a busy slot");

endmodule

// ===== rtl/timed_event_slot_scheduler.sv =====
// ----------------------------------------------------------------------------
// timed_event_slot_scheduler
// Event slot table with generation-checked handles: schedule, cancel and
// tick requests, fired-event results and a next-deadline summary.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Busy then stays
// high while the request runs through the ST_SCAN and ST_SUM states: the
// table is scanned one slot per cycle through the slot memories, with a read
// of the next slot overlapping the check of the current one, and ST_SUM
// then forms the summary. A tick delivers each fired event on result_valid
// as its slot is checked, at most one per cycle and at most 16 per tick; the
// summary, with last high, follows once the scan is done. Every result is
// shown for exactly one cycle and must be captured then, as it cannot be held
// off. Results come in slot order, and the summary is always the final one.
// ----------------------------------------------------------------------------
module timed_event_slot_scheduler #(
    parameter int SLOTS = tess_pkg::SLOTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [tess_pkg::REQ_W-1:0]       req_type,
    input  logic [tess_pkg::TIME_W-1:0]      current_time,
    input  logic [tess_pkg::TIME_W-1:0]      deadline,
    input  logic [tess_pkg::TAG_W-1:0]       event_tag,
    input  logic [tess_pkg::HIDX_W-1:0]      handle_index,
    input  logic [tess_pkg::GEN_W-1:0]       handle_generation,
    output logic                             result_valid,
    output logic                             result_kind,
    output logic                             status,
    output logic [tess_pkg::SLOT_IDX_W-1:0]  slot_index,
    output logic [tess_pkg::GEN_W-1:0]       slot_generation,
    output logic [tess_pkg::TAG_W-1:0]       fired_tag,
    output logic [tess_pkg::TIME_W-1:0]      next_deadline,
    output logic                             next_valid,
    output logic                             fire_now,
    output logic                             last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    tess_pkg::dp_cmd_t  cmd;
    logic [IDX_W-1:0]   rd_idx;
    logic [IDX_W-1:0]   chk_idx;

    tess_ctrl #(
        .SLOTS   (SLOTS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .rd_idx  (rd_idx),
        .chk_idx (chk_idx)
    );

    tess_dpath #(
        .SLOTS             (SLOTS)
    ) u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .rd_idx            (rd_idx),
        .chk_idx           (chk_idx),
        .req_type          (req_type),
        .current_time      (current_time),
        .deadline          (deadline),
        .event_tag         (event_tag),
        .handle_index      (handle_index),
        .handle_generation (handle_generation),
        .result_valid      (result_valid),
        .result_kind       (result_kind),
        .status            (status),
        .slot_index        (slot_index),
        .slot_generation   (slot_generation),
        .fired_tag         (fired_tag),
        .next_deadline     (next_deadline),
        .next_valid        (next_valid),
        .fire_now          (fire_now),
        .last              (last)
    );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the timed event slot scheduler. Requests go in
// through start/busy one at a time and results are captured on result_valid.
// A behavioural copy of the slot table predicts every fired event and
// summary, including generation checks and wrap-aware deadline compares.
// After a directed set the bench runs rounds that fill, churn and drain the
// table.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NSLOTS = tess_pkg::SLOTS_DEF;
    localparam logic [tess_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam int N_RANDOM = 280;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 2 * (NSLOTS + 2) + 4;

    typedef enum int { ROUND_MIXED, ROUND_FILL, ROUND_DRAIN } round_t;

    typedef struct {
        logic [tess_pkg::REQ_W-1:0]  req;
        logic [tess_pkg::TIME_W-1:0] now;
        logic [tess_pkg::TIME_W-1:0] dl;
        logic [tess_pkg::TAG_W-1:0]  tag;
        logic [tess_pkg::HIDX_W-1:0] hidx;
        logic [tess_pkg::GEN_W-1:0]  hgen;
        int                          gap;
        bit                          idle_only;
        bit                          drain;
    } request_t;

    typedef struct {
        logic                            kind;
        logic                            status;
        logic [tess_pkg::SLOT_IDX_W-1:0] idx;
        logic [tess_pkg::GEN_W-1:0]      gen;
        logic [tess_pkg::TAG_W-1:0]      tag;
        logic [tess_pkg::TIME_W-1:0]     nd;
        logic                            nv;
        logic                            fn;
        logic                            last;
    } outcome_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    logic [tess_pkg::REQ_W-1:0]      req_type = '0;
    logic [tess_pkg::TIME_W-1:0]     current_time = '0;
    logic [tess_pkg::TIME_W-1:0]     deadline = '0;
    logic [tess_pkg::TAG_W-1:0]      event_tag = '0;
    logic [tess_pkg::HIDX_W-1:0]     handle_index = '0;
    logic [tess_pkg::GEN_W-1:0]      handle_generation = '0;
    logic                            result_valid;
    logic                            result_kind;
    logic                            status;
    logic [tess_pkg::SLOT_IDX_W-1:0] slot_index;
    logic [tess_pkg::GEN_W-1:0]      slot_generation;
    logic [tess_pkg::TAG_W-1:0]      fired_tag;
    logic [tess_pkg::TIME_W-1:0]     next_deadline;
    logic                            next_valid;
    logic                            fire_now;
    logic                            last;

    // shadow slot table
    bit                        sh_pending  [NSLOTS];
    bit [tess_pkg::TIME_W-1:0] sh_deadline [NSLOTS];
    bit [tess_pkg::GEN_W-1:0]  sh_gen      [NSLOTS];
    bit [tess_pkg::TAG_W-1:0]  sh_tag      [NSLOTS];

    request_t request_q [$];
    outcome_t expected_results [$];
    request_t cur_req;
    bit       drv_active = 1'b0;
    int       gap_left = 0;
    int       calm_left = 0;
    int       cycle_count = 0;
    int       mismatches = 0;
    int       n_results = 0;
    int       n_accepted = 0;
    int       n_sched_ok = 0;
    int       n_full = 0;
    int       n_cancel_ok = 0;
    int       n_cancel_bad = 0;
    int       n_ticks = 0;
    int       n_fired = 0;
    int       n_drains = 0;

    timed_event_slot_scheduler #(
        .SLOTS(NSLOTS)
    ) u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .req_type          (req_type),
        .current_time      (current_time),
        .deadline          (deadline),
        .event_tag         (event_tag),
        .handle_index      (handle_index),
        .handle_generation (handle_generation),
        .result_valid      (result_valid),
        .result_kind       (result_kind),
        .status            (status),
        .slot_index        (slot_index),
        .slot_generation   (slot_generation),
        .fired_tag         (fired_tag),
        .next_deadline     (next_deadline),
        .next_valid        (next_valid),
        .fire_now          (fire_now),
        .last              (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch @%0d: %s", cycle_count, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      n_results, name, got, want));
    endtask

    // Applies one request to the shadow table and queues the results it causes.
    task automatic apply_request(input request_t r);
        outcome_t                        o;
        logic [tess_pkg::TIME_W-1:0]     diff;
        logic [tess_pkg::TIME_W-1:0]     best_dt;
        logic [tess_pkg::TIME_W-1:0]     pick;
        logic [tess_pkg::GEN_W-1:0]      g;
        logic                            found;
        logic                            stop;
        logic                            sts;
        logic [tess_pkg::SLOT_IDX_W-1:0] s_idx;
        logic [tess_pkg::GEN_W-1:0]      s_gen;
        int                              n_out;
        sts = 1'b0;
        s_idx = '0;
        s_gen = '0;
        n_out = 0;
        case (r.req)
            tess_pkg::REQ_SCHED:
            begin
                sts = 1'b1;
                stop = 1'b0;
                for (int i = 0; i < NSLOTS; i++)
                begin
                    if (!stop && !sh_pending[i])
                    begin
                        g = sh_gen[i] + 1'b1;
                        if (g == '0)
                            g = tess_pkg::GEN_W'(1);
                        sh_gen[i] = g;
                        sh_pending[i] = 1'b1;
                        sh_deadline[i] = r.dl;
                        sh_tag[i] = r.tag;
                        sts = 1'b0;
                        s_idx = tess_pkg::SLOT_IDX_W'(i);
                        s_gen = g;
                        stop = 1'b1;
                    end
                end
                if (sts)
                    n_full++;
                else
                    n_sched_ok++;
            end
            tess_pkg::REQ_CANCEL:
            begin
                sts = 1'b1;
                if (r.hidx < NSLOTS && r.hgen != '0 && sh_pending[r.hidx]
                    && sh_gen[r.hidx] == r.hgen)
                begin
                    sh_pending[r.hidx] = 1'b0;
                    sts = 1'b0;
                end
                if (sts)
                    n_cancel_bad++;
                else
                    n_cancel_ok++;
            end
            tess_pkg::REQ_TICK:
            begin
                n_ticks++;
                for (int i = 0; i < NSLOTS; i++)
                begin
                    diff = r.now - sh_deadline[i];
                    if (sh_pending[i] && !diff[tess_pkg::TIME_W-1] &&
                        n_out < tess_pkg::MAX_FIRED)
                    begin
                        o = '{kind: 1'b1, status: 1'b0,
                              idx: tess_pkg::SLOT_IDX_W'(i), gen: '0,
                              tag: sh_tag[i], nd: '0, nv: 1'b0, fn: 1'b0,
                              last: 1'b0};
                        expected_results.push_back(o);
                        sh_pending[i] = 1'b0;
                        n_out++;
                        n_fired++;
                    end
                end
            end
            default:
                sts = 1'b1;
        endcase

        // next deadline: first overdue slot, else the nearest future one
        found = 1'b0;
        stop = 1'b0;
        best_dt = '0;
        pick = '0;
        for (int i = 0; i < NSLOTS; i++)
        begin
            if (!stop && sh_pending[i])
            begin
                diff = sh_deadline[i] - r.now;
                if (!diff[tess_pkg::TIME_W-1])
                begin
                    if (!found || diff < best_dt)
                    begin
                        best_dt = diff;
                        pick = sh_deadline[i];
                        found = 1'b1;
                    end
                end
                else
                begin
                    pick = sh_deadline[i];
                    found = 1'b1;
                    stop = 1'b1;
                end
            end
        end
        diff = r.now - pick;
        o = '{kind: 1'b0, status: sts, idx: s_idx, gen: s_gen, tag: '0,
              nd: found ? pick : '0, nv: found,
              fn: found && !diff[tess_pkg::TIME_W-1], last: 1'b1};
        expected_results.push_back(o);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            drv_active <= 1'b0;
            gap_left <= 0;
        end
        else if (drv_active)
        begin
            if (start)
            begin
                if (!busy)
                begin
                    apply_request(cur_req);
                    n_accepted++;
                    start <= 1'b0;
                    drv_active <= 1'b0;
                end
            end
            else if (gap_left != 0)
            begin
                if (!(cur_req.idle_only && busy))
                    gap_left <= gap_left - 1;
            end
            else if (!cur_req.drain || expected_results.size() == 0)
            begin
                start <= 1'b1;
                req_type <= cur_req.req;
                current_time <= cur_req.now;
                deadline <= cur_req.dl;
                event_tag <= cur_req.tag;
                handle_index <= cur_req.hidx;
                handle_generation <= cur_req.hgen;
            end
        end
        else if (request_q.size() != 0)
        begin
            cur_req = request_q.pop_front();
            drv_active <= 1'b1;
            gap_left <= cur_req.gap;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          n_results));
            else
            begin
                outcome_t want;
                want = expected_results.pop_front();
                check_field("result_kind", result_kind, want.kind);
                check_field("status", status, want.status);
                check_field("slot_index", slot_index, want.idx);
                check_field("slot_generation", slot_generation, want.gen);
                check_field("fired_tag", fired_tag, want.tag);
                check_field("next_deadline", next_deadline, want.nd);
                check_field("next_valid", next_valid, want.nv);
                check_field("fire_now", fire_now, want.fn);
                check_field("last", last, want.last);
            end
            n_results++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic request_t mk(input logic [tess_pkg::REQ_W-1:0] req,
                                    input logic [tess_pkg::TIME_W-1:0] now,
                                    input logic [tess_pkg::TIME_W-1:0] dl,
                                    input logic [tess_pkg::TAG_W-1:0] tag,
                                    input logic [tess_pkg::HIDX_W-1:0] hidx,
                                    input logic [tess_pkg::GEN_W-1:0] hgen);
        request_t r;
        r = '{req: req, now: now, dl: dl, tag: tag, hidx: hidx, hgen: hgen,
              gap: 0, idle_only: 1'b0, drain: 1'b0};
        return r;
    endfunction

    // Hands one request to the driver and waits until it has been taken.
    task automatic send(input request_t r);
        if (calm_left > 0)
        begin
            r.gap = 0;
            calm_left--;
        end
        else
        begin
            r.gap = $urandom_range(0, 14);
            if ($urandom_range(0, 19) == 0)
                calm_left = $urandom_range(8, 30);
        end
        r.idle_only = $urandom_range(0, 1);
        if (r.drain)
            n_drains++;
        request_q.push_back(r);
        @(negedge clk);
        while (request_q.size() != 0 || drv_active)
            @(negedge clk);
    endtask

    initial
    begin
        request_t                    r;
        round_t                      round_kind;
        int                          round_left;
        int                          sel;
        int                          idx;
        int                          live [$];
        logic [tess_pkg::TIME_W-1:0] t_now;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed
        send(mk(tess_pkg::REQ_TICK, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0));
        send(mk(tess_pkg::REQ_CANCEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                16'hFFFF, 16'hFFFF, 16'hFFFF));
        send(mk(REQ_UNKNOWN, 32'h1234_5678, 32'h8765_4321,
                16'hA5A5, 16'h5A5A, 16'h0001));
        send(mk(tess_pkg::REQ_SCHED, 32'hFFFF_FFF0, 32'h0000_0010,
                16'hFFFF, 16'h0, 16'h0));
        send(mk(tess_pkg::REQ_SCHED, 32'hFFFF_FFF0, 32'hFFFF_FFF8,
                16'h1234, 16'h0, 16'h0));
        send(mk(tess_pkg::REQ_SCHED, 32'hFFFF_FFF0, 32'hFFFF_FFF0,
                16'h0000, 16'h0, 16'h0));
        send(mk(tess_pkg::REQ_SCHED, 32'hFFFF_FFF0, 32'hFFFF_FFF8,
                16'h5555, 16'h0, 16'h0));
        send(mk(tess_pkg::REQ_CANCEL, 32'hFFFF_FFF1, 32'h0, 16'h0, 16'd2, 16'h0));
        send(mk(tess_pkg::REQ_CANCEL, 32'hFFFF_FFF1, 32'h0, 16'h0, 16'd2,
                sh_gen[2] + 1'b1));
        send(mk(tess_pkg::REQ_CANCEL, 32'hFFFF_FFF1, 32'h0, 16'h0, 16'd2, sh_gen[2]));
        send(mk(tess_pkg::REQ_CANCEL, 32'hFFFF_FFF1, 32'h0, 16'h0, 16'd2, sh_gen[2]));
        send(mk(tess_pkg::REQ_SCHED, 32'hFFFF_FFF0, 32'h7FFF_FFEF,
                16'h00FF, 16'h0, 16'h0));
        send(mk(tess_pkg::REQ_SCHED, 32'hFFFF_FFF0, 32'h7FFF_FFF0,
                16'hFF00, 16'h0, 16'h0));
        send(mk(tess_pkg::REQ_SCHED, 32'h0000_0010, 32'h0000_0000,
                16'hAAAA, 16'h0, 16'h0));
        send(mk(REQ_UNKNOWN, 32'h0000_0010, 32'h0, 16'h0, 16'h0, 16'h0));
        send(mk(tess_pkg::REQ_TICK, 32'h0000_0010, 32'h0, 16'h0, 16'h0, 16'h0));
        send(mk(tess_pkg::REQ_TICK, 32'h7FFF_FFF0, 32'h0, 16'h0, 16'h0, 16'h0));
        send(mk(tess_pkg::REQ_TICK, 32'h8000_0000, 32'h0, 16'h0, 16'h0, 16'h0));
        send(mk(tess_pkg::REQ_SCHED, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                16'hFFFF, 16'hFFFF, 16'hFFFF));
        send(mk(tess_pkg::REQ_CANCEL, 32'hFFFF_FFFF, 32'h0, 16'h0,
                tess_pkg::HIDX_W'(NSLOTS), 16'd1));
        send(mk(tess_pkg::REQ_CANCEL, 32'hFFFF_FFFF, 32'h0, 16'h0, 16'd0, 16'hFFFF));
        send(mk(tess_pkg::REQ_CANCEL, 32'hFFFF_FFFF, 32'h0, 16'h0, 16'd0, sh_gen[0]));

        // random rounds
        t_now = $urandom();
        round_left = 0;
        round_kind = ROUND_FILL;
        for (int k = 0; k < N_RANDOM; k++)
        begin
            if (round_left == 0)
            begin
                if (k == 0)
                begin
                    round_kind = ROUND_FILL;
                    round_left = 40;
                end
                else
                begin
                    round_kind = round_t'($urandom_range(0, 2));
                    round_left = $urandom_range(20, 40);
                end
            end
            round_left--;

            if ($urandom_range(0, 39) == 0)
                t_now = $urandom();
            else
                t_now = t_now + $urandom_range(0, 200);

            r = mk(tess_pkg::REQ_SCHED, t_now, $urandom(),
                   tess_pkg::TAG_W'($urandom_range(0, 65535)),
                   tess_pkg::HIDX_W'($urandom_range(0, 65535)),
                   tess_pkg::GEN_W'($urandom_range(0, 65535)));
            r.drain = (k == 0) || ($urandom_range(0, 49) == 0);

            sel = $urandom_range(0, 99);
            if ((round_kind == ROUND_MIXED && sel < 40) ||
                (round_kind == ROUND_FILL && sel < 85) ||
                (round_kind == ROUND_DRAIN && sel < 20))
            begin
                r.req = tess_pkg::REQ_SCHED;
                case (round_kind)
                    ROUND_FILL:  r.dl = t_now + $urandom_range(2000, 200000);
                    ROUND_DRAIN: r.dl = t_now + $urandom_range(0, 1000);
                    default:
                    begin
                        sel = $urandom_range(0, 99);
                        if (sel < 70)
                            r.dl = t_now + $urandom_range(0, 2000);
                        else if (sel < 85)
                            r.dl = t_now - $urandom_range(0, 500);
                        else
                            r.dl = t_now + $urandom_range(0, 20);
                    end
                endcase
            end
            else if ((round_kind == ROUND_MIXED && sel < 65) ||
                     (round_kind == ROUND_FILL && sel < 90) ||
                     (round_kind == ROUND_DRAIN && sel < 45))
            begin
                r.req = tess_pkg::REQ_CANCEL;
                live = {};
                for (int i = 0; i < NSLOTS; i++)
                    if (sh_pending[i])
                        live.push_back(i);
                sel = $urandom_range(0, 99);
                if (live.size() != 0 && sel < 85)
                begin
                    idx = live[$urandom_range(0, live.size() - 1)];
                    r.hidx = tess_pkg::HIDX_W'(idx);
                    if (sel < 70)
                        r.hgen = sh_gen[idx];
                    else
                        r.hgen = sh_gen[idx] + tess_pkg::GEN_W'($urandom_range(1, 3));
                end
                else if (sel < 92)
                begin
                    r.hidx = tess_pkg::HIDX_W'($urandom_range(0, NSLOTS - 1));
                    r.hgen = sh_gen[r.hidx];
                end
            end
            else if ((round_kind == ROUND_MIXED && sel < 95) ||
                     (round_kind == ROUND_FILL && sel < 98) ||
                     (round_kind == ROUND_DRAIN && sel < 95))
            begin
                r.req = tess_pkg::REQ_TICK;
                if (round_kind == ROUND_DRAIN && $urandom_range(0, 99) < 30)
                    t_now = t_now + $urandom_range(50000, 300000);
                r.now = t_now;
            end
            else
            begin
                // noise: unknown request, junk cancel, or schedule at a random time
                sel = $urandom_range(0, 2);
                if (sel == 0)
                    r.req = REQ_UNKNOWN;
                else if (sel == 1)
                    r.req = tess_pkg::REQ_CANCEL;
                else
                    r.now = $urandom();
            end
            send(r);
        end

        while (request_q.size() != 0 || drv_active)
            @(negedge clk);
        for (int w = 0; w < 400 && expected_results.size() != 0; w++)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_results.size()));

        $display("covered %0d requests: %0d scheduled, %0d on a full table, %0d/%0d cancels",
                 n_accepted, n_sched_ok, n_full, n_cancel_ok, n_cancel_bad);
        $display("%0d ticks fired %0d events, %0d results, %0d drain pauses, %0d mismatches",
                 n_ticks, n_fired, n_results, n_drains, mismatches);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
